// ----- sv/slfw_pkg.sv -----
package slfw_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_NIBBLE = 2'd1,
        OP_START  = 2'd2,
        OP_BYTE   = 2'd3
    } opcode_t;

    // Bit counter width; covers the longest frame over the address width range
    localparam int CNT_W = 4;

    // Frame prefixes, sent MSB first
    localparam logic [3:0] CMD_PREFIX   = 4'b1000;
    localparam logic [2:0] WRITE_PREFIX = 3'b101;

    // Bit lengths of the fixed parts of a frame
    localparam int CMD_LEN  = 12;
    localparam int BYTE_LEN = 8;

    // Control half of a decoded frame
    typedef struct packed {
        logic [CNT_W-1:0] bits;        // number of write-clock edges
        logic             release_cs;  // chip select rises after the last edge
        logic             rejected;    // refused request, one empty edge
    } frame_ctl_t;

endpackage

// ----- sv/slfw_item_stage.sv -----
// Input register: decodes one request into a left-aligned frame word and
// tracks whether a successive frame is open.
module slfw_item_stage #(
    parameter int ADDRESS_BITS = 6,
    parameter int FRAME_W      = 13
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  slfw_pkg::opcode_t        opcode,
    input  logic [5:0]               address,
    input  logic [7:0]               data_byte,
    input  logic                     close_frame,
    input  logic                     take,
    output logic                     hold_valid,
    output logic [FRAME_W-1:0]       hold_word,
    output slfw_pkg::frame_ctl_t     hold_ctl
);

    localparam int NIB_LEN   = 7 + ADDRESS_BITS;
    localparam int START_LEN = 3 + ADDRESS_BITS;

    logic                     frame_open_reg;
    logic                     frame_open_next;
    logic                     hold_valid_reg;
    logic [FRAME_W-1:0]       hold_word_reg;
    logic [FRAME_W-1:0]       word_next;
    slfw_pkg::frame_ctl_t     hold_ctl_reg;
    slfw_pkg::frame_ctl_t     ctl_next;
    logic [ADDRESS_BITS-1:0]  addr_ext;
    logic                     accept;

    assign in_ready = !hold_valid_reg || take;
    assign accept   = in_valid && in_ready;
    assign addr_ext = ADDRESS_BITS'(address);

    // Frame build
    always_comb begin
        word_next           = '0;
        ctl_next.bits       = slfw_pkg::CNT_W'(1);
        ctl_next.release_cs = 1'b0;
        ctl_next.rejected   = 1'b1;
        frame_open_next     = frame_open_reg;
        unique case (opcode)
            slfw_pkg::OP_BYTE: begin
                if (frame_open_reg) begin
                    word_next = FRAME_W'(data_byte) << (FRAME_W - slfw_pkg::BYTE_LEN);
                    ctl_next.bits       = slfw_pkg::CNT_W'(slfw_pkg::BYTE_LEN);
                    ctl_next.release_cs = close_frame;
                    ctl_next.rejected   = 1'b0;
                    frame_open_next     = !close_frame;
                end
            end
            slfw_pkg::OP_CMD: begin
                if (!frame_open_reg) begin
                    word_next = FRAME_W'({slfw_pkg::CMD_PREFIX, data_byte})
                                << (FRAME_W - slfw_pkg::CMD_LEN);
                    ctl_next.bits       = slfw_pkg::CNT_W'(slfw_pkg::CMD_LEN);
                    ctl_next.release_cs = 1'b1;
                    ctl_next.rejected   = 1'b0;
                end
            end
            slfw_pkg::OP_NIBBLE: begin
                if (!frame_open_reg) begin
                    word_next = FRAME_W'({slfw_pkg::WRITE_PREFIX, addr_ext, data_byte[7:4]})
                                << (FRAME_W - NIB_LEN);
                    ctl_next.bits       = slfw_pkg::CNT_W'(NIB_LEN);
                    ctl_next.release_cs = 1'b1;
                    ctl_next.rejected   = 1'b0;
                end
            end
            slfw_pkg::OP_START: begin
                if (!frame_open_reg) begin
                    word_next = FRAME_W'({slfw_pkg::WRITE_PREFIX, addr_ext})
                                << (FRAME_W - START_LEN);
                    ctl_next.bits       = slfw_pkg::CNT_W'(START_LEN);
                    ctl_next.release_cs = close_frame;
                    ctl_next.rejected   = 1'b0;
                    frame_open_next     = !close_frame;
                end
            end
            default: begin
                frame_open_next = frame_open_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                frame_open_reg <= frame_open_next;
                hold_valid_reg <= 1'b1;
            end else if (take) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Frame payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_word_reg <= word_next;
            hold_ctl_reg  <= ctl_next;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_word  = hold_word_reg;
    assign hold_ctl   = hold_ctl_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> hold_valid_reg)
        else $error("accepted transaction did not reach the input register");

    a_byte_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && opcode == slfw_pkg::OP_BYTE && !frame_open_reg |=> hold_ctl_reg.rejected)
        else $error("byte outside an open frame was not refused");

    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && opcode == slfw_pkg::OP_START && !frame_open_reg && !close_frame
        |=> frame_open_reg)
        else $error("successive start did not open a frame");
`endif

endmodule

// ----- sv/slfw_serializer.sv -----
// Output register and shifter: sends the held frame one bit per transaction,
// MSB first, and loads the next frame in the cycle the last bit leaves.
module slfw_serializer #(
    parameter int FRAME_W = 13
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  hold_valid,
    input  logic [FRAME_W-1:0]    hold_word,
    input  slfw_pkg::frame_ctl_t  hold_ctl,
    output logic                  take,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  serial_bit,
    output logic                  select_release,
    output logic                  rejected,
    output logic                  last
);

    logic                          out_valid_reg;
    logic [FRAME_W-1:0]            shift_reg;
    logic [slfw_pkg::CNT_W-1:0]    bits_left_reg;
    logic                          release_reg;
    logic                          rejected_reg;
    logic                          advance;
    logic                          final_bit;

    assign final_bit = bits_left_reg == slfw_pkg::CNT_W'(1);
    assign advance   = !out_valid_reg || out_ready;
    // Load a new frame when empty or when the last bit is being taken
    assign take      = hold_valid && advance && (!out_valid_reg || final_bit);

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            if (out_valid_reg && !final_bit) begin
                out_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= hold_valid;
            end
        end
    end

    // Shift word and bit count
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (out_valid_reg && !final_bit) begin
                shift_reg     <= shift_reg << 1;
                bits_left_reg <= bits_left_reg - slfw_pkg::CNT_W'(1);
            end else if (take) begin
                shift_reg     <= hold_word;
                bits_left_reg <= hold_ctl.bits;
                release_reg   <= hold_ctl.release_cs;
                rejected_reg  <= hold_ctl.rejected;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign serial_bit     = shift_reg[FRAME_W-1];
    assign last           = final_bit;
    assign select_release = final_bit && release_reg;
    assign rejected       = rejected_reg;

`ifndef SYNTHESIS
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> bits_left_reg != '0)
        else $error("output valid with no bits left");

    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && rejected_reg |-> final_bit && !shift_reg[FRAME_W-1])
        else $error("refused request sent more than one empty edge");

    a_take_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !out_valid_reg || (out_ready && final_bit))
        else $error("frame loaded while a frame was still shifting");
`endif

endmodule

// ----- sv/segment_lcd_serial_frame_writer.sv -----
// Serial frame writer for a three-wire segment-LCD controller. Each input
// transaction is one write request (opcode on s_axis_tuser, close_frame on
// s_axis_tlast); it produces one output transaction per write-clock edge,
// data bit MSB first, with m_axis_tlast on the final edge of the request.
// Edge counts: command 12, nibble write 7+ADDRESS_BITS (13 at the default
// address width), successive start 3+ADDRESS_BITS, successive byte 8, refused
// request 1. The output shifter sends one bit per cycle while m_axis_tready
// is high; the input register takes the next request while the current
// frame is shifting, so frames can follow each other back to back.
module segment_lcd_serial_frame_writer #(
    parameter int ADDRESS_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] address, [13:6] data_byte, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        s_axis_tlast,   // close_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] serial_bit, [7:1] zero
    output logic [1:0]  m_axis_tuser,   // [0] select_release, [1] rejected
    output logic        m_axis_tlast    // last
);

    localparam int FRAME_W = (7 + ADDRESS_BITS > slfw_pkg::CMD_LEN) ?
                             7 + ADDRESS_BITS : slfw_pkg::CMD_LEN;

    logic                  take;
    logic                  hold_valid;
    logic [FRAME_W-1:0]    hold_word;
    slfw_pkg::frame_ctl_t  hold_ctl;
    logic                  serial_bit;
    logic                  select_release;
    logic                  rejected;

    slfw_item_stage #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .FRAME_W      (FRAME_W)
    ) u_item_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (slfw_pkg::opcode_t'(s_axis_tuser)),
        .address     (s_axis_tdata[5:0]),
        .data_byte   (s_axis_tdata[13:6]),
        .close_frame (s_axis_tlast),
        .take        (take),
        .hold_valid  (hold_valid),
        .hold_word   (hold_word),
        .hold_ctl    (hold_ctl)
    );

    slfw_serializer #(
        .FRAME_W (FRAME_W)
    ) u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .hold_valid     (hold_valid),
        .hold_word      (hold_word),
        .hold_ctl       (hold_ctl),
        .take           (take),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .serial_bit     (serial_bit),
        .select_release (select_release),
        .rejected       (rejected),
        .last           (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, serial_bit};
    assign m_axis_tuser = {rejected, select_release};

endmodule
